// ===== rtl/frq_pkg.sv =====
package frq_pkg;

    localparam int PIX_IO_BITS   = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;
    localparam int DIM_REG_BITS  = 7;

    localparam logic [DIM_REG_BITS-1:0] DIM_RESET = 7'd64;

    typedef enum logic [0:0] {
        REQ_LOAD  = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_LOAD_FULL   = 2'd1,
        ST_DRAIN_EARLY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ANG_0   = 2'd0,
        ANG_90  = 2'd1,
        ANG_180 = 2'd2,
        ANG_270 = 2'd3
    } t_angle;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ANGLE  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic capture;
        logic coord;
        logic addr;
        logic mem;
        logic put;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_ctrl_stat;

endpackage

// ===== rtl/frq_req_if.sv =====
interface frq_req_if;
    logic                                  valid;
    logic                                  ready;
    frq_pkg::t_req                         req_type;
    logic [frq_pkg::PIX_IO_BITS-1:0]       pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

// ===== rtl/frq_rsp_if.sv =====
interface frq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [frq_pkg::PIX_IO_BITS-1:0]       pixel_out;
    logic                                  frame_last;
    frq_pkg::t_status                      status;

    modport source (output valid, output pixel_out, output frame_last, output status,
                    input ready);
    modport sink   (input valid, input pixel_out, input frame_last, input status,
                    output ready);
endinterface

// ===== rtl/frq_ctrl.sv =====
module frq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  frq_pkg::t_ctrl_stat i_stat,
    output frq_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_COORD = 5'b00010,
        S_ADDR  = 5'b00100,
        S_MEM   = 5'b01000,
        S_PUT   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_COORD;
                end
            end
            S_COORD: begin
                o_cmd.coord = 1'b1;
                n_state     = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_MEM;
            end
            S_MEM: begin
                o_cmd.mem = 1'b1;
                n_state   = S_PUT;
            end
            S_PUT: begin
                if (i_stat.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/frq_dp.sv =====
module frq_dp #(
    parameter int MAX_DIM    = 64,
    parameter int PIXEL_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [frq_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [frq_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  frq_pkg::t_ctrl_cmd                  i_cmd,
    output frq_pkg::t_ctrl_stat                 o_stat,
    input  frq_pkg::t_req                       i_req_type,
    input  logic [frq_pkg::PIX_IO_BITS-1:0]     i_pixel_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [frq_pkg::PIX_IO_BITS-1:0]     o_pixel_out,
    output logic                                o_frame_last,
    output frq_pkg::t_status                    o_status
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int PW    = $clog2(MAX_DIM);
    localparam int EW    = (DW > frq_pkg::DIM_REG_BITS) ? DW : frq_pkg::DIM_REG_BITS;
    localparam int LW    = PW + DW + 1;

    function automatic logic [DW-1:0] clamp_dim(input logic [frq_pkg::DIM_REG_BITS-1:0] d);
        logic [DW-1:0] res;
        if (d == '0) begin
            res = DW'(1);
        end else if (EW'(d) > EW'(MAX_DIM)) begin
            res = DW'(MAX_DIM);
        end else begin
            res = DW'(d);
        end
        return res;
    endfunction

    // configuration
    frq_pkg::t_angle                   r_angle;
    logic [frq_pkg::DIM_REG_BITS-1:0]  r_cfg_w;
    logic [frq_pkg::DIM_REG_BITS-1:0]  r_cfg_h;

    // frame state
    logic [CW-1:0]  r_load_cnt;
    logic [CW-1:0]  n_load_cnt;
    logic           r_full;
    logic [PW-1:0]  r_out_col;
    logic [PW-1:0]  r_out_row;

    // staged word
    frq_pkg::t_req       r_req;
    logic [PIXEL_BITS-1:0] r_pix;
    logic [DW-1:0]       r_w;
    logic [DW-1:0]       r_h;
    logic [PW-1:0]       r_sx;
    logic [PW-1:0]       r_sy;
    logic                r_last;
    logic                r_col_end;
    frq_pkg::t_status    r_status;
    logic [AW-1:0]       r_addr;
    logic [CW-1:0]       r_total;
    logic [PIXEL_BITS-1:0] r_rdata;

    logic [PIXEL_BITS-1:0] r_mem [DEPTH];

    // output register
    logic                              r_out_valid;
    logic [frq_pkg::PIX_IO_BITS-1:0]   r_out_pix;
    logic                              r_out_last;
    frq_pkg::t_status                  r_out_status;

    logic [DW-1:0]     w_w, w_h, w_ow, w_oh;
    logic [DW-1:0]     w_wm1, w_hm1, w_owm1, w_ohm1;
    logic [DW-1:0]     w_hx, w_wx, w_hy, w_wy;
    logic              w_col_end, w_row_end;
    logic [PW-1:0]     w_x, w_y, w_sx, w_sy;
    frq_pkg::t_status  w_status;
    logic [2*DW-1:0]   w_prod;
    logic [LW-1:0]     w_lin;
    logic              w_ok;
    logic              w_ok_drain;

    always_comb begin
        w_w       = clamp_dim(r_cfg_w);
        w_h       = clamp_dim(r_cfg_h);
        w_ow      = r_angle[0] ? w_h : w_w;
        w_oh      = r_angle[0] ? w_w : w_h;
        w_wm1     = w_w - DW'(1);
        w_hm1     = w_h - DW'(1);
        w_owm1    = w_ow - DW'(1);
        w_ohm1    = w_oh - DW'(1);
        w_col_end = (DW'(r_out_col) >= w_owm1);
        w_row_end = (DW'(r_out_row) >= w_ohm1);
        w_x       = w_col_end ? w_owm1[PW-1:0] : r_out_col;
        w_y       = w_row_end ? w_ohm1[PW-1:0] : r_out_row;
        w_hx      = w_hm1 - DW'(w_x);
        w_wx      = w_wm1 - DW'(w_x);
        w_hy      = w_hm1 - DW'(w_y);
        w_wy      = w_wm1 - DW'(w_y);
        unique case (r_angle)
            frq_pkg::ANG_90: begin
                w_sx = w_y;
                w_sy = w_hx[PW-1:0];
            end
            frq_pkg::ANG_180: begin
                w_sx = w_wx[PW-1:0];
                w_sy = w_hy[PW-1:0];
            end
            frq_pkg::ANG_270: begin
                w_sx = w_wy[PW-1:0];
                w_sy = w_x;
            end
            default: begin
                w_sx = w_x;
                w_sy = w_y;
            end
        endcase
        if (r_req == frq_pkg::REQ_LOAD) begin
            w_status = r_full ? frq_pkg::ST_LOAD_FULL : frq_pkg::ST_OK;
        end else begin
            w_status = r_full ? frq_pkg::ST_OK : frq_pkg::ST_DRAIN_EARLY;
        end
    end

    assign w_prod     = r_w * r_h;
    assign w_lin      = r_sy * r_w + r_sx;
    assign n_load_cnt = r_load_cnt + CW'(1);
    assign w_ok       = (r_status == frq_pkg::ST_OK);
    assign w_ok_drain = w_ok && (r_req == frq_pkg::REQ_DRAIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle     <= frq_pkg::ANG_0;
            r_cfg_w     <= frq_pkg::DIM_RESET;
            r_cfg_h     <= frq_pkg::DIM_RESET;
            r_load_cnt  <= '0;
            r_full      <= 1'b0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    frq_pkg::CFG_ANGLE:  r_angle <= frq_pkg::t_angle'(i_cfg_data[1:0]);
                    frq_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                    frq_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.mem && w_ok) begin
                if (r_req == frq_pkg::REQ_LOAD) begin
                    r_load_cnt <= n_load_cnt;
                    if (n_load_cnt >= r_total) begin
                        r_full <= 1'b1;
                    end
                end else if (r_last) begin
                    r_load_cnt <= '0;
                    r_full     <= 1'b0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                end else if (r_col_end) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + PW'(1);
                end else begin
                    r_out_col <= r_out_col + PW'(1);
                end
            end
            if (i_cmd.put) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req_type;
            r_pix <= PIXEL_BITS'(i_pixel_in);
        end
        if (i_cmd.coord) begin
            r_w       <= w_w;
            r_h       <= w_h;
            r_sx      <= w_sx;
            r_sy      <= w_sy;
            r_last    <= w_col_end && w_row_end;
            r_col_end <= w_col_end;
            r_status  <= w_status;
        end
        if (i_cmd.addr) begin
            r_total <= w_prod[CW-1:0];
            r_addr  <= (r_req == frq_pkg::REQ_LOAD) ? r_load_cnt[AW-1:0] : w_lin[AW-1:0];
        end
        if (i_cmd.put) begin
            r_out_pix    <= w_ok_drain ? frq_pkg::PIX_IO_BITS'(r_rdata) : '0;
            r_out_last   <= w_ok_drain && r_last;
            r_out_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem) begin
            if (w_ok && (r_req == frq_pkg::REQ_LOAD)) begin
                r_mem[r_addr] <= r_pix;
            end
            r_rdata <= r_mem[r_addr];
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_pixel_out     = r_out_pix;
    assign o_frame_last    = r_out_last;
    assign o_status        = r_out_status;

    a_refused_word_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != frq_pkg::ST_OK)) |-> ((r_out_pix == '0) && !r_out_last))
        else $error("refused word carries data");

    a_load_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_cnt <= CW'(DEPTH))
        else $error("load count beyond store depth");

    a_put_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |=> r_out_valid)
        else $error("output register not loaded");

endmodule

// ===== rtl/frame_rotate_quarter_turns.sv =====
// Each accepted input word steps through coord, addr, mem and put before its result
// word is valid; a new word is taken only in idle, after the last word's put step,
// as set by the five-step sequence around the single-port frame memory.
// A result waits in an output register; a later word holds at its put step until it frees.
// Reset (synchronous, active low) clears control, configuration, counters and the output
// valid flag; staged words and frame memory are undefined until written, no clearing pass.
module frame_rotate_quarter_turns #(
    parameter int MAX_DIM    = 64,
    parameter int PIXEL_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [frq_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [frq_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    frq_req_if.sink                            i_req,
    frq_rsp_if.source                          o_rsp
);

    frq_pkg::t_ctrl_cmd  w_cmd;
    frq_pkg::t_ctrl_stat w_stat;
    logic                w_req_ready;

    frq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    frq_dp #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_req_type   (i_req.req_type),
        .i_pixel_in   (i_req.pixel_in),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_pixel_out  (o_rsp.pixel_out),
        .o_frame_last (o_rsp.frame_last),
        .o_status     (o_rsp.status)
    );

    assign i_req.ready = w_req_ready;

endmodule
